// ----- sv/lii_pkg.sv -----
// ============================================================================
// lii_pkg: shared types and constants for the linear intensity unit
// Word sizes, request/result payloads, configuration record, status codes
// and the job record that travels down the square-root and divider pipes.
// ============================================================================
`default_nettype none

package lii_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;

  // Derived widths
  localparam int RATE_BITS  = 2 * WORD_BITS + 1;              // alpha<<F + beta*t0
  localparam int PROD_BITS  = 4 * WORD_BITS;                  // full square / product
  localparam int DISC_BITS  = 4 * WORD_BITS + 2;              // signed discriminant
  localparam int ROOT_BITS  = 2 * WORD_BITS;                  // square root of PROD_BITS
  localparam int SQREM_BITS = 2 * WORD_BITS + 2;              // root remainder
  localparam int NUM_BITS   = 4 * WORD_BITS - 2 * FRAC_BITS;  // divider numerator

  localparam int SQRT_STAGES = ROOT_BITS;
  localparam int DIV_STAGES  = NUM_BITS;

  // Request kinds
  localparam logic REQ_FORWARD = 1'b0;
  localparam logic REQ_INVERSE = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EARLY     = 3'd1;
  localparam logic [2:0] ST_ZERO_RATE = 3'd2;
  localparam logic [2:0] ST_NEG_DISC  = 3'd3;
  localparam logic [2:0] ST_SAT       = 3'd4;

  // Configuration register indexes
  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RATE_INTERCEPT = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RATE_SLOPE     = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_START_TIME     = 2'd2;

  localparam logic [WORD_BITS-1:0] SLOPE_RESET = WORD_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic                        req_type;
    logic signed [WORD_BITS-1:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] value;
    logic [2:0]                  status;
  } rsp_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] rate_intercept;
    logic signed [WORD_BITS-1:0] rate_slope;
    logic signed [WORD_BITS-1:0] start_time;
  } cfg_t;

  typedef struct packed {
    logic [2:0]           status;
    logic                 neg;        // negate the quotient
    logic                 add_t0;     // add start time after the divide
    logic                 need_sqrt;  // numerator comes from the root
    logic [NUM_BITS-1:0]  num;        // numerator, becomes the quotient
    logic [WORD_BITS-1:0] den;
    logic [PROD_BITS-1:0] rad;        // radicand
  } job_t;

  typedef struct packed {
    job_t                  job;
    logic [ROOT_BITS-1:0]  root;
    logic [SQREM_BITS-1:0] rem;
  } sq_t;

  typedef struct packed {
    job_t                 job;
    logic [WORD_BITS-1:0] rem;
  } dv_t;

  function automatic logic [WORD_BITS-1:0] mag_word(input logic signed [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (WORD_BITS'(~v) + WORD_BITS'(1)) : WORD_BITS'(v);
  endfunction

  // alpha scaled to the product's fraction position
  function automatic logic signed [RATE_BITS-1:0] scale_rate(
    input logic signed [WORD_BITS-1:0] v);
    logic signed [RATE_BITS-1:0] e;
    e = RATE_BITS'(v);
    return e <<< FRAC_BITS;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lii_front.sv -----
// ============================================================================
// lii_front: operand preparation and wide multiply
// Eight register stages: differences, narrow products, clamp test, the
// two-limb magnitude multiply, and formation of the divide/root job.
// ============================================================================
`default_nettype none

module lii_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  lii_pkg::req_t req,
  input  lii_pkg::cfg_t cfg,
  output logic          out_valid,
  output lii_pkg::job_t job
);

  localparam int W  = lii_pkg::WORD_BITS;
  localparam int F  = lii_pkg::FRAC_BITS;
  localparam int R  = lii_pkg::RATE_BITS;
  localparam int P  = lii_pkg::PROD_BITS;
  localparam int D  = lii_pkg::DISC_BITS;
  localparam int NB = lii_pkg::NUM_BITS;

  typedef struct packed {
    logic                typ;
    logic signed [W-1:0] x;
    logic signed [2*W-1:0] bx;
    logic                early;
    logic                clamp;
    logic                zr;
    logic                msign;
  } side_t;

  logic signed [W-1:0] a, b, t0;
  assign a  = cfg.rate_intercept;
  assign b  = cfg.rate_slope;
  assign t0 = cfg.start_time;

  logic [7:1] vld;

  // stage 1
  logic                typ1;
  logic signed [W-1:0] x1;

  // stage 2
  logic                  typ2, early2;
  logic signed [W-1:0]   x2;
  logic signed [W:0]     d2, s2;
  logic signed [2*W-1:0] bx2, bt02;

  // stage 3
  logic                  typ3, early3, clamp3, zr3;
  logic signed [W-1:0]   x3;
  logic signed [W:0]     d3;
  logic signed [2*W:0]   bs3;
  logic signed [R-1:0]   r03;
  logic signed [2*W-1:0] bx3;

  // stages 4..7
  side_t            side4, side5, side6, side7;
  logic [2*W-1:0]   ma4, mb4;
  logic [2*W-1:0]   p00, p01, p10, p11;
  logic [2*W:0]     mid6;
  logic [4*W-1:0]   cat6;
  logic [P-1:0]     prod7;

  // combinational
  logic signed [W:0]     d_c, s_c;
  logic                  early_c;
  logic signed [2*W-1:0] bx_c, bt0_c;
  logic signed [R-1:0]   as_c, r0_c, cs_c;
  logic signed [2*W:0]   bs_c;
  logic signed [2*W+1:0] f_c;
  logic [2*W-1:0]        absf_c, absr0_c, ma_c, mb_c;
  logic                  msign_c;
  logic signed [R-1:0]   r0neg_c;

  assign as_c    = lii_pkg::scale_rate(a);
  assign d_c     = (W+1)'(x1) - (W+1)'(t0);
  assign s_c     = (W+1)'(x1) + (W+1)'(t0);
  assign early_c = x1 < t0;
  assign bx_c    = x1 * b;
  assign bt0_c   = t0 * b;

  assign bs_c    = s2 * b;
  assign r0_c    = as_c + R'(bt02);
  assign cs_c    = R'(bx2) + as_c;

  assign f_c     = ((2*W+2)'(as_c) <<< 1) + (2*W+2)'(bs3);
  assign absf_c  = f_c[2*W+1] ? (2*W)'(-f_c) : (2*W)'(f_c);
  assign r0neg_c = -r03;
  assign absr0_c = r03[R-1] ? (2*W)'(r0neg_c) : (2*W)'(r03);

  always_comb begin
    if (typ3 == lii_pkg::REQ_FORWARD && !clamp3) begin
      ma_c    = (2*W)'(d3[W-1:0]);
      mb_c    = absf_c;
      msign_c = f_c[2*W+1];
    end else begin
      ma_c    = absr0_c;
      mb_c    = absr0_c;
      msign_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[6:1], in_valid};
      out_valid <= vld[7];
    end
  end

  // stages 1..3
  always_ff @(posedge clk) begin
    typ1   <= req.req_type;
    x1     <= req.operand;

    typ2   <= typ1;
    x2     <= x1;
    d2     <= d_c;
    s2     <= s_c;
    early2 <= early_c;
    bx2    <= bx_c;
    bt02   <= bt0_c;

    typ3   <= typ2;
    x3     <= x2;
    d3     <= d2;
    bs3    <= bs_c;
    r03    <= r0_c;
    bx3    <= bx2;
    early3 <= early2;
    clamp3 <= b[W-1] & cs_c[R-1];
    zr3    <= (a == '0) && (b == '0);
  end

  // stages 4..7: limb multiply of the magnitudes
  always_ff @(posedge clk) begin
    side4.typ   <= typ3;
    side4.x     <= x3;
    side4.bx    <= bx3;
    side4.early <= early3;
    side4.clamp <= clamp3;
    side4.zr    <= zr3;
    side4.msign <= msign_c;
    ma4         <= ma_c;
    mb4         <= mb_c;

    side5 <= side4;
    p00   <= ma4[W-1:0]   * mb4[W-1:0];
    p01   <= ma4[W-1:0]   * mb4[2*W-1:W];
    p10   <= ma4[2*W-1:W] * mb4[W-1:0];
    p11   <= ma4[2*W-1:W] * mb4[2*W-1:W];

    side6 <= side5;
    mid6  <= (2*W+1)'(p01) + (2*W+1)'(p10);
    cat6  <= {p11, p00};

    side7 <= side6;
    prod7 <= P'(cat6) + (P'(mid6) << W);
  end

  // stage 8: build the job
  logic signed [2*W-1:0] bx7;
  logic signed [W-1:0]   x7;
  logic signed [D-1:0]   disc_c;
  logic [P:0]            fsum_c, csum_c;
  logic [W-1:0]          absa_c, absb_c, absx_c;
  lii_pkg::job_t         job_c;

  assign bx7    = side7.bx;
  assign x7     = side7.x;
  assign absa_c = lii_pkg::mag_word(a);
  assign absb_c = lii_pkg::mag_word(b);
  assign absx_c = lii_pkg::mag_word(x7);
  assign disc_c = $signed({2'b00, prod7}) + (D'(bx7) <<< (2*F+1));
  assign fsum_c = (P+1)'(prod7) + ((P+1)'(1) << (2*F));
  assign csum_c = (P+1)'(prod7) + ((P+1)'(absb_c) << (2*F));

  always_comb begin
    job_c           = '0;
    job_c.status    = lii_pkg::ST_OK;
    job_c.den       = W'(1);
    if (side7.typ == lii_pkg::REQ_FORWARD) begin
      if (side7.early) begin
        job_c.status = lii_pkg::ST_EARLY;
      end else if (side7.clamp) begin
        job_c.num = NB'(csum_c >> (2*F+1));
        job_c.den = absb_c;
      end else begin
        job_c.num = NB'(fsum_c >> (2*F+1));
        job_c.neg = side7.msign;
      end
    end else begin
      if (side7.zr) begin
        job_c.status = lii_pkg::ST_ZERO_RATE;
      end else if (b != '0) begin
        job_c.need_sqrt = 1'b1;
        job_c.rad       = disc_c[P-1:0];
        job_c.den       = absb_c;
        if (disc_c[D-1]) begin
          job_c.status = lii_pkg::ST_NEG_DISC;
        end
      end else begin
        job_c.num    = (NB'(absx_c) << F) + NB'(absa_c >> 1);
        job_c.den    = absa_c;
        job_c.neg    = x7[W-1] ^ a[W-1];
        job_c.add_t0 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    job <= job_c;
  end

endmodule

`default_nettype wire

// ----- sv/lii_sqrt.sv -----
// ============================================================================
// lii_sqrt: pipelined integer square root
// One root bit per stage, then a stage that turns the root into the
// divider numerator for inverse requests with a nonzero slope whose discriminant is not negative.
// ============================================================================
`default_nettype none

module lii_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  lii_pkg::job_t job_in,
  input  lii_pkg::cfg_t cfg,
  output logic          out_valid,
  output lii_pkg::job_t job_out
);

  localparam int W  = lii_pkg::WORD_BITS;
  localparam int P  = lii_pkg::PROD_BITS;
  localparam int RB = lii_pkg::ROOT_BITS;
  localparam int QB = lii_pkg::SQREM_BITS;
  localparam int NB = lii_pkg::NUM_BITS;
  localparam int NS = lii_pkg::SQRT_STAGES;

  function automatic lii_pkg::sq_t sq_step(input lii_pkg::sq_t s);
    lii_pkg::sq_t  t;
    logic [QB-1:0] rem2;
    logic [QB-1:0] trial;
    t       = s;
    rem2    = {s.rem[QB-3:0], s.job.rad[P-1 -: 2]};
    trial   = {s.root, 2'b01};
    t.job.rad = s.job.rad << 2;
    if (rem2 >= trial) begin
      t.rem  = rem2 - trial;
      t.root = {s.root[RB-2:0], 1'b1};
    end else begin
      t.rem  = rem2;
      t.root = {s.root[RB-2:0], 1'b0};
    end
    return t;
  endfunction

  lii_pkg::sq_t st [NS];
  logic [NS-1:0] vld;
  lii_pkg::sq_t  head;

  always_comb begin
    head      = '0;
    head.job  = job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[NS-2:0], in_valid};
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= sq_step(head);
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      st[k] <= sq_step(st[k-1]);
    end
  end

  // root minus alpha, rounded-division numerator
  logic signed [W-1:0]    a, b;
  logic signed [2*W+1:0]  n_c;
  logic [2*W+1:0]         nneg_c;
  logic [2*W:0]           absn_c;
  logic [W-1:0]           absb_c;
  lii_pkg::job_t          last_c;
  lii_pkg::job_t          conv_c;

  assign a      = cfg.rate_intercept;
  assign b      = cfg.rate_slope;
  assign last_c = st[NS-1].job;
  assign n_c    = $signed({2'b00, st[NS-1].root}) - (2*W+2)'(lii_pkg::scale_rate(a));
  assign nneg_c = -n_c;
  assign absn_c = n_c[2*W+1] ? nneg_c[2*W:0] : n_c[2*W:0];
  assign absb_c = lii_pkg::mag_word(b);

  always_comb begin
    conv_c = last_c;
    if (last_c.need_sqrt && last_c.status == lii_pkg::ST_OK) begin
      conv_c.num = NB'(absn_c) + NB'(absb_c >> 1);
      conv_c.neg = n_c[2*W+1] ^ b[W-1];
    end
  end

  always_ff @(posedge clk) begin
    job_out <= conv_c;
  end

endmodule

`default_nettype wire

// ----- sv/lii_div.sv -----
// ============================================================================
// lii_div: pipelined restoring divider
// One quotient bit per stage; the numerator shifts out as the quotient
// shifts in, so the job leaves with num holding the quotient.
// ============================================================================
`default_nettype none

module lii_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  lii_pkg::job_t job_in,
  output logic          out_valid,
  output lii_pkg::job_t job_out
);

  localparam int W  = lii_pkg::WORD_BITS;
  localparam int NB = lii_pkg::NUM_BITS;
  localparam int NS = lii_pkg::DIV_STAGES;

  function automatic lii_pkg::dv_t dv_step(input lii_pkg::dv_t s);
    lii_pkg::dv_t t;
    logic [W:0]   trial;
    logic [W:0]   dext;
    logic         qbit;
    t     = s;
    trial = {s.rem, s.job.num[NB-1]};
    dext  = {1'b0, s.job.den};
    qbit  = trial >= dext;
    if (qbit) begin
      t.rem = W'(trial - dext);
    end else begin
      t.rem = trial[W-1:0];
    end
    t.job.num = {s.job.num[NB-2:0], qbit};
    return t;
  endfunction

  lii_pkg::dv_t  st [NS];
  logic [NS-1:0] vld;
  lii_pkg::dv_t  head;

  always_comb begin
    head     = '0;
    head.job = job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= dv_step(head);
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      st[k] <= dv_step(st[k-1]);
    end
  end

  assign out_valid = vld[NS-1];
  assign job_out   = st[NS-1].job;

endmodule

`default_nettype wire

// ----- sv/linear_intensity_integral_and_inverse_top.sv -----
// ============================================================================
// linear_intensity_integral_and_inverse_top: linear-rate cumulative intensity
// Forward integral and inverse solve of alpha + beta*t from t0, Q16.16.
// ============================================================================
// A request is taken at every clock edge with start high (busy stays low),
// one per cycle with no gaps needed. Each request yields exactly one result,
// strobed by done for a single cycle. The path is 171 register stages, the
// first loading at the accepting edge: 8 operand/multiply stages, 64
// square-root stages (one root bit each) plus one conversion stage, 96
// divider stages (one quotient bit each), and two stages for sign, offset
// and saturation. The result side has no back pressure; results must be
// captured when done is high. Configuration writes are applied at once and
// must only be made with no request in flight.
`default_nettype none

module linear_intensity_integral_and_inverse_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  lii_pkg::req_t                       req,
  output logic                                done,
  output lii_pkg::rsp_t                       rsp,
  input  logic                                cfg_we,
  input  logic [lii_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [lii_pkg::WORD_BITS-1:0]       cfg_wdata
);

  localparam int W  = lii_pkg::WORD_BITS;
  localparam int NB = lii_pkg::NUM_BITS;

  localparam logic signed [NB+1:0] VMAX = (NB+2)'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [NB+1:0] VMIN = ~VMAX;

  lii_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_intercept <= '0;
      cfg.rate_slope     <= lii_pkg::SLOPE_RESET;
      cfg.start_time     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lii_pkg::REG_RATE_INTERCEPT: cfg.rate_intercept <= cfg_wdata;
        lii_pkg::REG_RATE_SLOPE:     cfg.rate_slope     <= cfg_wdata;
        lii_pkg::REG_START_TIME:     cfg.start_time     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic          f_valid, s_valid, d_valid;
  lii_pkg::job_t f_job, s_job, d_job;

  lii_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .req      (req),
    .cfg      (cfg),
    .out_valid(f_valid),
    .job      (f_job)
  );

  lii_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .job_in   (f_job),
    .cfg      (cfg),
    .out_valid(s_valid),
    .job_out  (s_job)
  );

  lii_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid),
    .job_in   (s_job),
    .out_valid(d_valid),
    .job_out  (d_job)
  );

  // sign and start-time offset
  logic signed [NB+1:0] qs_c, tadd_c, sv_c, sv1;
  logic signed [W-1:0]  t0;
  logic [2:0]           st1;
  logic                 v1;

  assign t0     = cfg.start_time;
  assign qs_c   = d_job.neg ? -$signed({2'b00, d_job.num}) : $signed({2'b00, d_job.num});
  assign tadd_c = d_job.add_t0 ? (NB+2)'(t0) : '0;
  assign sv_c   = qs_c + tadd_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    sv1 <= sv_c;
    st1 <= d_job.status;
  end

  // saturate, drop the value on an error status
  lii_pkg::rsp_t rsp_c;

  always_comb begin
    if (st1 != lii_pkg::ST_OK) begin
      rsp_c.value  = '0;
      rsp_c.status = st1;
    end else if (sv1 > VMAX) begin
      rsp_c.value  = VMAX[W-1:0];
      rsp_c.status = lii_pkg::ST_SAT;
    end else if (sv1 < VMIN) begin
      rsp_c.value  = VMIN[W-1:0];
      rsp_c.status = lii_pkg::ST_SAT;
    end else begin
      rsp_c.value  = sv1[W-1:0];
      rsp_c.status = lii_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_c;
  end

endmodule

`default_nettype wire

// ----- sim/lii_checker.sv -----
// ============================================================================
// lii_checker: result predictor and scoreboard for the linear intensity unit
// Tracks configuration writes, computes the expected value and status of every
// accepted request and compares each strobed result with the oldest one.
// ============================================================================
`default_nettype none

module lii_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  lii_pkg::req_t                     req,
  input  logic                              done,
  input  lii_pkg::rsp_t                     rsp,
  input  logic                              cfg_we,
  input  logic [lii_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [lii_pkg::WORD_BITS-1:0]     cfg_wdata,
  output int                                errors,
  output int                                outstanding,
  output int                                checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] big_t;

  lii_pkg::cfg_t shadow;
  lii_pkg::rsp_t expected_q[$];

  function automatic big_t root_floor(input big_t n);
    big_t res, bitv, t;
    res = '0;
    bitv = big_t'(1) <<< 190;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      t = res + bitv;
      if (n >= t) begin
        n = n - t;
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // round to nearest, halves away from zero
  function automatic big_t div_round(input big_t n, input big_t d);
    big_t an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (an + (ad >>> 1)) / ad;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic lii_pkg::rsp_t intensity_result(input lii_pkg::cfg_t c,
                                                     input lii_pkg::req_t r);
    big_t a, b, t0, x, as, r0, num, den, q, disc;
    lii_pkg::rsp_t o;
    a  = c.rate_intercept;
    b  = c.rate_slope;
    t0 = c.start_time;
    x  = r.operand;
    as = a <<< lii_pkg::FRAC_BITS;
    r0 = as + b * t0;
    o.value = '0;
    o.status = lii_pkg::ST_OK;
    q = '0;
    if (r.req_type == lii_pkg::REQ_FORWARD) begin
      if (x < t0) begin
        o.status = lii_pkg::ST_EARLY;
        return o;
      end
      if (b < 0 && (x * b + as) < 0) begin
        // clamp at the root of the rate
        num = -(r0 * r0);
        den = b <<< (2 * lii_pkg::FRAC_BITS + 1);
      end else begin
        num = (x - t0) * ((as <<< 1) + b * (x + t0));
        den = big_t'(1) <<< (2 * lii_pkg::FRAC_BITS + 1);
      end
      q = div_round(num, den);
    end else begin
      if (a == 0 && b == 0) begin
        o.status = lii_pkg::ST_ZERO_RATE;
        return o;
      end else if (b != 0) begin
        disc = r0 * r0 + ((b * x) <<< (2 * lii_pkg::FRAC_BITS + 1));
        if (disc < 0) begin
          o.status = lii_pkg::ST_NEG_DISC;
          return o;
        end
        q = div_round(root_floor(disc) - as, b);
      end else begin
        q = div_round(x <<< lii_pkg::FRAC_BITS, a) + t0;
      end
    end
    if (q > big_t'(32'sh7fff_ffff)) begin
      o.status = lii_pkg::ST_SAT;
      o.value = 32'sh7fff_ffff;
    end else if (q < big_t'(-33'sh8000_0000)) begin
      o.status = lii_pkg::ST_SAT;
      o.value = 32'sh8000_0000;
    end else begin
      o.value = q[lii_pkg::WORD_BITS-1:0];
    end
    return o;
  endfunction

  assign outstanding = expected_q.size();

  always @(posedge clk) begin
    lii_pkg::rsp_t e;
    logic          bad;
    bad = 1'b0;
    if (rst) begin
      shadow.rate_intercept <= '0;
      shadow.rate_slope     <= lii_pkg::SLOPE_RESET;
      shadow.start_time     <= '0;
      expected_q.delete();
      errors  <= 0;
      checked <= 0;
    end else begin
      if (start && !busy) expected_q.push_back(intensity_result(shadow, req));
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result value=%0d status=%0d", rsp.value, rsp.status);
          bad = 1'b1;
        end else begin
          e = expected_q.pop_front();
          checked <= checked + 1;
          if (rsp.value !== e.value) begin
            $error("value: expected %0d actual %0d", e.value, rsp.value);
            bad = 1'b1;
          end
          if (rsp.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, rsp.status);
            bad = 1'b1;
          end
        end
      end
      if (bad) errors <= errors + 1;
      if (cfg_we) begin
        case (cfg_addr)
          lii_pkg::REG_RATE_INTERCEPT: shadow.rate_intercept <= cfg_wdata;
          lii_pkg::REG_RATE_SLOPE:     shadow.rate_slope     <= cfg_wdata;
          lii_pkg::REG_START_TIME:     shadow.start_time     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_linear_intensity_integral_and_inverse_top.sv -----
// ============================================================================
// tb_linear_intensity_integral_and_inverse_top: stimulus and verdict
// Steps the unit through a series of rate settings, sends forward and inverse
// requests with random gaps, and reports the scoreboard outcome.
// ============================================================================
`default_nettype none

module tb_linear_intensity_integral_and_inverse_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 171;
  localparam int WB      = lii_pkg::WORD_BITS;
  localparam logic [lii_pkg::CFG_ADDR_BITS-1:0] REG_UNUSED = 2'd3;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  lii_pkg::req_t                     req;
  logic                              done;
  lii_pkg::rsp_t                     rsp;
  logic                              cfg_we;
  logic [lii_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
  logic [WB-1:0]                     cfg_wdata;
  int                                errors;
  int                                outstanding;
  int                                checked;
  int                                sent;
  int                                phases;
  bit                                steady;

  linear_intensity_integral_and_inverse_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  lii_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .errors(errors), .outstanding(outstanding),
    .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send(input logic kind, input logic [WB-1:0] operand);
    logic b;
    while (!steady && $urandom_range(99) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req.req_type <= kind;
    req.operand <= operand;
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
    sent++;
  endtask

  // drain, then load a new rate setting
  task automatic reconfigure(input logic [WB-1:0] a, input logic [WB-1:0] s,
                             input logic [WB-1:0] t0);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= lii_pkg::REG_RATE_INTERCEPT;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_addr <= lii_pkg::REG_RATE_SLOPE;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_addr <= lii_pkg::REG_START_TIME;
    cfg_wdata <= t0;
    @(posedge clk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  function automatic logic [WB-1:0] pick_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: return WB'($signed($urandom_range(2000000)) - 1000000);
      2: return WB'($signed($urandom_range(40000)) - 20000) <<< 4;
      default: return WB'($signed($urandom_range(600)) - 300) <<< lii_pkg::FRAC_BITS;
    endcase
  endfunction

  task automatic random_burst(input int n);
    for (int i = 0; i < n; i++) send(logic'($urandom_range(1)), pick_word());
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    sent = 0;
    phases = 0;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: unit slope from zero
    send(lii_pkg::REQ_FORWARD, 32'h0000_0000);
    send(lii_pkg::REQ_FORWARD, 32'h7fff_ffff);
    send(lii_pkg::REQ_FORWARD, 32'h8000_0000);
    send(lii_pkg::REQ_FORWARD, 32'h0003_0000);
    send(lii_pkg::REQ_INVERSE, 32'h0000_0000);
    send(lii_pkg::REQ_INVERSE, 32'h8000_0000);
    send(lii_pkg::REQ_INVERSE, 32'h7fff_ffff);
    send(lii_pkg::REQ_INVERSE, 32'h0004_8000);

    // zero rate, then constant rate
    reconfigure(32'h0, 32'h0, 32'h0);
    send(lii_pkg::REQ_INVERSE, 32'h0001_0000);
    send(lii_pkg::REQ_FORWARD, 32'h0005_0000);
    reconfigure(32'h0002_0000, 32'h0, 32'hffff_0000);
    send(lii_pkg::REQ_INVERSE, 32'h0001_0001);
    send(lii_pkg::REQ_INVERSE, 32'h7fff_ffff);
    send(lii_pkg::REQ_INVERSE, 32'h8000_0000);
    send(lii_pkg::REQ_FORWARD, 32'hfffe_0000);

    // falling rate: clamp at the root, root before start
    reconfigure(32'h0004_0000, 32'hffff_0000, 32'h0001_0000);
    send(lii_pkg::REQ_FORWARD, 32'h0002_0000);
    send(lii_pkg::REQ_FORWARD, 32'h0010_0000);
    send(lii_pkg::REQ_INVERSE, 32'h0010_0000);
    reconfigure(32'hfffc_0000, 32'hffff_0000, 32'h0001_0000);
    send(lii_pkg::REQ_FORWARD, 32'h0002_0000);
    send(lii_pkg::REQ_INVERSE, 32'hffff_0000);

    // extremes of the registers
    reconfigure(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send(lii_pkg::REQ_FORWARD, 32'h7fff_ffff);
    send(lii_pkg::REQ_INVERSE, 32'h7fff_ffff);
    reconfigure(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send(lii_pkg::REQ_FORWARD, 32'h7fff_ffff);
    send(lii_pkg::REQ_INVERSE, 32'h8000_0000);
    send(lii_pkg::REQ_INVERSE, 32'h0000_0001);

    // an unused register index must be ignored
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_UNUSED;
    cfg_wdata <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
    random_burst(20);

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: reconfigure($urandom(), $urandom(), $urandom());
        1: reconfigure(pick_word(), 32'h0, pick_word());
        default: reconfigure(pick_word(), pick_word(), pick_word());
      endcase
      steady = (p == 6);
      random_burst(100);
    end
    steady = 1'b0;

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("sent %0d requests over %0d rate settings, %0d results checked",
             sent, phases + 1, checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- linear_intensity_integral_and_inverse_top.f -----
sv/lii_pkg.sv
sv/lii_front.sv
sv/lii_sqrt.sv
sv/lii_div.sv
sv/linear_intensity_integral_and_inverse_top.sv
sim/lii_checker.sv
sim/tb_linear_intensity_integral_and_inverse_top.sv
